@@ rtl/rnf_pkg.sv @@
// shared types, constants and helper functions of the radix number formatter
// no dependencies
`timescale 1ns / 1ps

package rnf_pkg;

  // field widths
  localparam int BASE_W    = 6;
  localparam int CHAR_W    = 7;
  localparam int CNT_OUT_W = 7;

  // radix limits and digit coding
  localparam logic [BASE_W-1:0] BASE_MIN      = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX      = 6'd36;
  localparam logic [BASE_W-1:0] DIGIT_LIMIT   = 6'd10;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER_A = 7'd65;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_LOAD
  } rnf_state_t;

  // status of the serial divider toward the sequencer
  typedef struct packed {
    logic              done;
    logic              quot_nz;
    logic [BASE_W-1:0] rem;
  } rnf_div_stat_t;

  // clamp the requested radix into 2..36
  function automatic logic [BASE_W-1:0] sat_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] res;
    res = b;
    if (b < BASE_MIN) res = BASE_MIN;
    if (b > BASE_MAX) res = BASE_MAX;
    return res;
  endfunction

  // remainder to ascii: digits then upper-case letters
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_LIMIT) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_LETTER_A + CHAR_W'(d - DIGIT_LIMIT);
    end
    return res;
  endfunction

endpackage

@@ rtl/rnf_divider.sv @@
// bit-serial restoring divider: one quotient bit per cycle
// depends on rnf_pkg
`timescale 1ns / 1ps

module rnf_divider #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [VALUE_WIDTH-1:0]         dividend,
  input  logic [rnf_pkg::BASE_W-1:0]     divisor,
  output logic [VALUE_WIDTH-1:0]         quotient,
  output rnf_pkg::rnf_div_stat_t         stat
);
  import rnf_pkg::*;

  localparam int CNTW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [BASE_W-1:0]      r_r, r_nxt;
  logic [BASE_W-1:0]      d_r;
  logic [CNTW-1:0]        cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic                   nz_r, nz_nxt;
  logic [BASE_W:0]        trial;
  logic                   qbit;

  // one restoring step: shift in the next dividend bit and try to subtract
  always_comb begin
    trial  = {r_r, q_r[VALUE_WIDTH-1]};
    qbit   = (trial >= {1'b0, d_r});
    r_nxt  = qbit ? BASE_W'(trial - {1'b0, d_r}) : BASE_W'(trial);
    q_nxt  = {q_r[VALUE_WIDTH-2:0], qbit};
    nz_nxt = nz_r | qbit;
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(VALUE_WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      q_r  <= dividend;
      r_r  <= '0;
      d_r  <= divisor;
      nz_r <= 1'b0;
    end else if (busy_r) begin
      q_r  <= q_nxt;
      r_r  <= r_nxt;
      nz_r <= nz_nxt;
    end
  end

  assign quotient     = q_r;
  assign stat.done    = done_r;
  assign stat.quot_nz = nz_r;
  assign stat.rem     = r_r;

  // a finished step count always ends the run
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a preceding run");

  // the remainder stays below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (r_r < d_r))
    else $error("divider remainder not below divisor");

  // a start is never issued while a run is in progress
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("divider restarted while busy");

endmodule

@@ rtl/rnf_digit_stack.sv @@
// digit store: one write port, one registered read port
// depends on rnf_pkg
`timescale 1ns / 1ps

module rnf_digit_stack #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [rnf_pkg::CHAR_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [rnf_pkg::CHAR_W-1:0] rd_data
);
  import rnf_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/radix_number_formatter.sv @@
// top level: integer to ascii conversion in a radix of 2..36
// depends on rnf_pkg, rnf_divider and rnf_digit_stack
`timescale 1ns / 1ps

// Usage
// in channel: one item is a number (low VALUE_WIDTH bits of value) and a base;
//   bases 0..1 act as 2 and 37..63 as 36.
// out channel: one item per digit, most significant first; tlast marks the
//   final digit and every item carries the total digit count. zero gives '0'.
// A bit-serial divider produces one digit per division, least significant
//   first, into a digit store. The store is then read back in reverse, each
//   digit through a registered read, then the output register.
// in_tready is high only between numbers; the next number is taken while the
//   final digit may still wait in the output register.
// A stalled receiver holds the output register and the read-back waits.
// Reset clears the sequencer and the output valid; the digit store is not
//   cleared, every entry is written before it is read.

module radix_number_formatter #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // value [63:0], base [69:64], zero [71:70]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // digit_char [6:0], digit_count [13:7], zero [15:14]
  output logic        out_tlast   // is_last
);
  import rnf_pkg::*;

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  rnf_state_t             state_r, state_nxt;
  logic [BASE_W-1:0]      base_r;
  logic [CW-1:0]          count_r;
  logic [AW-1:0]          ptr_r;
  logic                   out_tvalid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;
  logic [CNT_OUT_W-1:0]   out_cnt_r;

  logic                   in_acc;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [BASE_W-1:0]      div_divisor;
  logic [VALUE_WIDTH-1:0] div_quot;
  rnf_div_stat_t          div_stat;
  logic                   wr_en;
  logic                   rd_en;
  logic [CHAR_W-1:0]      rd_data;
  logic                   out_load;
  logic                   next_div;

  assign in_acc = in_tvalid && in_tready;

  // serial divider
  rnf_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // digit store, written least significant first
  rnf_digit_stack #(
    .DEPTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (digit_to_ascii(div_stat.rem)),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_stat.done) state_nxt = div_stat.quot_nz ? ST_DIVIDE : ST_READ;
      end
      ST_READ:   state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (out_load) state_nxt = (ptr_r == '0) ? ST_IDLE : ST_READ;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready    = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    next_div     = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quot;
    div_divisor  = base_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        div_start    = in_tvalid;
        div_dividend = in_tdata[VALUE_WIDTH-1:0];
        // first division takes the base straight from the incoming item
        div_divisor  = sat_base(in_tdata[69:64]);
      end
      ST_DIVIDE: begin
        wr_en     = div_stat.done;
        next_div  = div_stat.done && div_stat.quot_nz;
        div_start = next_div;
      end
      ST_READ:   rd_en = 1'b1;
      ST_LOAD:   out_load = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  // state register and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // digit bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r  <= sat_base(in_tdata[69:64]);
      count_r <= '0;
    end
    if (wr_en) begin
      count_r <= count_r + 1'b1;
      if (!div_stat.quot_nz) ptr_r <= count_r[AW-1:0];
    end
    if (out_load && ptr_r != '0) begin
      ptr_r <= ptr_r - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= rd_data;
      out_last_r <= (ptr_r == '0);
      out_cnt_r  <= CNT_OUT_W'(count_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_char_r};

  // an accepted number always starts a division
  a_accept_divides: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_DIVIDE)
    else $error("accepted number did not start a division");

  // the digit store never overflows
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> count_r < CW'(VALUE_WIDTH))
    else $error("digit store overflow");

  // loading the final digit marks it last and returns to idle
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ptr_r == '0) |=> out_tlast && out_tvalid && state_r == ST_IDLE)
    else $error("final digit not flagged or sequencer not idle");

  // a read is always followed by the load stage
  a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_LOAD)
    else $error("read stage not followed by load");

  // digits emitted never exceed the digits stored
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> CW'(ptr_r) < count_r)
    else $error("read pointer beyond stored digits");

endmodule
